// ----- rtl/chd_pkg.sv -----
// Shared types, constants and the arctangent table of the compass heading block.
`default_nettype none

package chd_pkg;

    // Number of vectoring micro-rotations, limited to the table length.
    localparam int ANGLE_ITERATIONS = 16;
    localparam int ATAN_ENTRIES     = 24;
    localparam int CORDIC_STAGES    =
        (ANGLE_ITERATIONS > ATAN_ENTRIES) ? ATAN_ENTRIES : ANGLE_ITERATIONS;

    // Cycles from an accepted transaction to its result strobe.
    localparam int LATENCY = CORDIC_STAGES + 4;

    // Quarter turn in accumulator units (1/1024 of a hundredth of a degree).
    localparam int QUARTER_TURN = 9216000;

    // Configuration register indexes.
    localparam logic [2:0] REG_HARD_IRON_X = 3'd0;
    localparam logic [2:0] REG_HARD_IRON_Y = 3'd1;
    localparam logic [2:0] REG_GAIN_X      = 3'd2;
    localparam logic [2:0] REG_GAIN_Y      = 3'd3;
    localparam logic [2:0] REG_DECLINATION = 3'd4;

    typedef logic signed [15:0] t_sample;
    typedef logic        [15:0] t_gain;
    typedef logic signed [16:0] t_diff;
    typedef logic signed [33:0] t_prod;
    typedef logic signed [35:0] t_vec;
    typedef logic signed [26:0] t_angle;
    typedef logic signed [16:0] t_heading;

    // Control bits that travel with every pipeline stage.
    typedef struct packed {
        logic valid;
        logic zero;
    } t_ctl;

    // atan(2^-i) in accumulator units, rounded to nearest.
    function automatic t_angle atan_entry(input logic [4:0] idx);
        t_angle v;
        case (idx)
            5'd0:    v = 27'sd4608000;
            5'd1:    v = 27'sd2720261;
            5'd2:    v = 27'sd1437311;
            5'd3:    v = 27'sd729602;
            5'd4:    v = 27'sd366217;
            5'd5:    v = 27'sd183287;
            5'd6:    v = 27'sd91666;
            5'd7:    v = 27'sd45836;
            5'd8:    v = 27'sd22918;
            5'd9:    v = 27'sd11459;
            5'd10:   v = 27'sd5730;
            5'd11:   v = 27'sd2865;
            5'd12:   v = 27'sd1432;
            5'd13:   v = 27'sd716;
            5'd14:   v = 27'sd358;
            5'd15:   v = 27'sd179;
            5'd16:   v = 27'sd90;
            5'd17:   v = 27'sd45;
            5'd18:   v = 27'sd22;
            5'd19:   v = 27'sd11;
            5'd20:   v = 27'sd6;
            5'd21:   v = 27'sd3;
            5'd22:   v = 27'sd1;
            5'd23:   v = 27'sd1;
            default: v = 27'sd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/chd_correct.sv -----
// Hard-iron offset and gain correction, two register stages.
`default_nettype none

module chd_correct (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    input  wire chd_pkg::t_sample i_field_x,
    input  wire chd_pkg::t_sample i_field_y,
    input  wire chd_pkg::t_sample i_hard_iron_x,
    input  wire chd_pkg::t_sample i_hard_iron_y,
    input  wire chd_pkg::t_gain   i_gain_x,
    input  wire chd_pkg::t_gain   i_gain_y,
    output chd_pkg::t_ctl         o_ctl,
    output chd_pkg::t_prod        o_xc,
    output chd_pkg::t_prod        o_yc
);
    import chd_pkg::*;

    logic  r_v1, r_v2;
    t_diff r_dx, r_dy, n_dx, n_dy;
    t_prod r_px, r_py, n_px, n_py;

    // Offset subtraction in 17 bits, then exact products with the Q2.14 gains.
    always_comb begin
        n_dx = {i_field_x[15], i_field_x} - {i_hard_iron_x[15], i_hard_iron_x};
        n_dy = {i_field_y[15], i_field_y} - {i_hard_iron_y[15], i_hard_iron_y};
        n_px = r_dx * $signed({1'b0, i_gain_x});
        n_py = r_dy * $signed({1'b0, i_gain_y});
    end

    // Valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_dx <= n_dx;
        r_dy <= n_dy;
        r_px <= n_px;
        r_py <= n_py;
    end

    assign o_ctl.valid = r_v2;
    assign o_ctl.zero  = (r_px == '0) || (r_py == '0);
    assign o_xc        = r_px;
    assign o_yc        = r_py;

    // A product is zero exactly when its difference or its gain was zero.
    a_zero_product: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1 && (r_dx == '0) |=> (r_px == '0))
        else $error("nonzero product from a zero offset difference");

endmodule

`default_nettype wire

// ----- rtl/chd_cordic.sv -----
// Pipelined vectoring CORDIC, one micro-rotation per register stage.
`default_nettype none

module chd_cordic (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire chd_pkg::t_ctl  i_ctl,
    input  wire chd_pkg::t_prod i_xc,
    input  wire chd_pkg::t_prod i_yc,
    output chd_pkg::t_ctl       o_ctl,
    output chd_pkg::t_angle     o_acc
);
    import chd_pkg::*;

    t_ctl   r_ctl [0:CORDIC_STAGES];
    t_angle r_acc [0:CORDIC_STAGES];
    t_vec   r_x   [0:CORDIC_STAGES-1];
    t_vec   r_y   [0:CORDIC_STAGES-1];
    t_vec   n_x0, n_y0, w_cx, w_sy;
    t_angle n_acc0;

    // The cosine side is the corrected y, the sine side the corrected x.
    assign w_cx = {{2{i_yc[33]}}, i_yc};
    assign w_sy = {{2{i_xc[33]}}, i_xc};

    // Turn a left half plane vector by a quarter turn into the CORDIC range.
    always_comb begin
        n_x0   = w_cx;
        n_y0   = w_sy;
        n_acc0 = '0;
        if (w_cx < 0) begin
            if (w_sy >= 0) begin
                n_x0   = w_sy;
                n_y0   = -w_cx;
                n_acc0 = 27'(QUARTER_TURN);
            end else begin
                n_x0   = -w_sy;
                n_y0   = w_cx;
                n_acc0 = -27'(QUARTER_TURN);
            end
        end
    end

    // Entry stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl[0] <= '0;
        end else begin
            r_ctl[0] <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x[0]   <= n_x0;
        r_y[0]   <= n_y0;
        r_acc[0] <= n_acc0;
    end

    // Micro-rotation stages.
    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_stage
        t_angle n_acc;

        always_comb begin
            if (r_y[g] >= 0) begin
                n_acc = r_acc[g] + atan_entry(5'(g));
            end else begin
                n_acc = r_acc[g] - atan_entry(5'(g));
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ctl[g+1] <= '0;
            end else begin
                r_ctl[g+1] <= r_ctl[g];
            end
        end

        always_ff @(posedge i_clk) begin
            r_acc[g+1] <= n_acc;
        end

        // The last stage only needs its angle.
        if (g < CORDIC_STAGES - 1) begin : g_vec
            t_vec n_x, n_y;

            always_comb begin
                if (r_y[g] >= 0) begin
                    n_x = r_x[g] + (r_y[g] >>> g);
                    n_y = r_y[g] - (r_x[g] >>> g);
                end else begin
                    n_x = r_x[g] - (r_y[g] >>> g);
                    n_y = r_y[g] + (r_x[g] >>> g);
                end
            end

            always_ff @(posedge i_clk) begin
                r_x[g+1] <= n_x;
                r_y[g+1] <= n_y;
            end
        end
    end

    assign o_ctl = r_ctl[CORDIC_STAGES];
    assign o_acc = r_acc[CORDIC_STAGES];

    // After the pre-rotation the cosine side is never negative.
    a_right_half: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ctl[0].valid && !r_ctl[0].zero |-> (r_x[0] >= 0))
        else $error("pre-rotated vector left the right half plane");

endmodule

`default_nettype wire

// ----- rtl/chd_finish.sv -----
// Rounding of the CORDIC angle, declination and the result register.
`default_nettype none

module chd_finish (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire chd_pkg::t_ctl    i_ctl,
    input  wire chd_pkg::t_angle  i_acc,
    input  wire chd_pkg::t_sample i_declination,
    output logic                  o_valid,
    output chd_pkg::t_heading     o_heading
);
    import chd_pkg::*;

    logic     r_valid;
    t_heading r_heading, n_heading, w_round;
    t_angle   w_sum;

    // Round half up to hundredths of a degree, then add the declination.
    assign w_sum   = i_acc + 27'sd512;
    assign w_round = w_sum[26:10];

    always_comb begin
        if (i_ctl.zero) begin
            n_heading = '0;
        end else begin
            n_heading = w_round + {i_declination[15], i_declination};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_heading <= n_heading;
    end

    assign o_valid   = r_valid;
    assign o_heading = r_heading;

    // A zero axis gives a zero heading without declination.
    a_zero_heading: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.valid && i_ctl.zero |=> (o_heading == '0))
        else $error("zero axis gave a nonzero heading");

    // The raw angle stays within half a turn either way.
    a_angle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.valid && !i_ctl.zero |-> (w_round >= -17'sd18000) && (w_round <= 17'sd18000))
        else $error("raw heading outside half a turn");

endmodule

`default_nettype wire

// ----- rtl/compass_heading.sv -----
// Top level of the magnetometer compass heading block.
//
//   Channel   Signals                                             Handshake
//   sample    start, busy, i_field_x, i_field_y                   start && !busy
//   config    i_cfg_valid, o_cfg_ready, i_cfg_index, i_cfg_data   i_cfg_valid && o_cfg_ready
//   result    o_heading_valid, o_heading                          strobe, one cycle
//
// One sample pair is taken in every cycle while busy is low; each result is formed
// by the offset, multiply and pre-rotation registers, one register stage per CORDIC
// micro-rotation and the rounding stage, in that order.
// Reset is synchronous and active low; busy is high for the cycle after reset.
// The receiver cannot stall, so the pipeline never holds and results leave in order.
`default_nettype none

module compass_heading (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire chd_pkg::t_sample    i_field_x,
    input  wire chd_pkg::t_sample    i_field_y,
    input  wire logic                i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire logic [2:0]          i_cfg_index,
    input  wire logic [15:0]         i_cfg_data,
    output logic                     o_heading_valid,
    output chd_pkg::t_heading        o_heading
);
    import chd_pkg::*;

    logic    r_ready;
    logic    w_accept;
    t_sample r_hard_iron_x, r_hard_iron_y, r_declination;
    t_gain   r_gain_x, r_gain_y;
    t_ctl    w_corr_ctl, w_cordic_ctl;
    t_prod   w_xc, w_yc;
    t_angle  w_acc;

    // Ready flag, low while in reset and for the first cycle after it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ready <= 1'b0;
        end else begin
            r_ready <= 1'b1;
        end
    end

    assign busy        = !r_ready;
    assign o_cfg_ready = r_ready;
    assign w_accept    = start && !busy;

    // Configuration registers; unknown indexes are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hard_iron_x <= '0;
            r_hard_iron_y <= '0;
            r_gain_x      <= 16'd16384;
            r_gain_y      <= 16'd16384;
            r_declination <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_HARD_IRON_X: r_hard_iron_x <= i_cfg_data;
                REG_HARD_IRON_Y: r_hard_iron_y <= i_cfg_data;
                REG_GAIN_X:      r_gain_x      <= i_cfg_data;
                REG_GAIN_Y:      r_gain_y      <= i_cfg_data;
                REG_DECLINATION: r_declination <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Offset and gain correction.
    chd_correct u_correct (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (w_accept),
        .i_field_x     (i_field_x),
        .i_field_y     (i_field_y),
        .i_hard_iron_x (r_hard_iron_x),
        .i_hard_iron_y (r_hard_iron_y),
        .i_gain_x      (r_gain_x),
        .i_gain_y      (r_gain_y),
        .o_ctl         (w_corr_ctl),
        .o_xc          (w_xc),
        .o_yc          (w_yc)
    );

    // Angle of the corrected vector.
    chd_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_corr_ctl),
        .i_xc    (w_xc),
        .i_yc    (w_yc),
        .o_ctl   (w_cordic_ctl),
        .o_acc   (w_acc)
    );

    // Rounding, declination and result register.
    chd_finish u_finish (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (w_cordic_ctl),
        .i_acc         (w_acc),
        .i_declination (r_declination),
        .o_valid       (o_heading_valid),
        .o_heading     (o_heading)
    );

    // Every result strobe answers a transaction taken a fixed latency earlier.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_heading_valid |-> $past(w_accept, LATENCY))
        else $error("result strobe without a matching transaction");

endmodule

`default_nettype wire

// ----- test/tb_compass_heading.sv -----
// Self-checking testbench for the compass heading block: samples, register writes and headings.
`timescale 1ns / 100ps

module tb_compass_heading;

    import chd_pkg::*;

    typedef struct packed {
        t_sample fx;
        t_sample fy;
    } t_sample_pair;

    typedef struct packed {
        t_sample  fx;
        t_sample  fy;
        t_heading heading;
    } t_due_heading;

    // atan(2^-i) in units of 1/1024 of a hundredth of a degree.
    localparam longint ARCTAN_STEP [ATAN_ENTRIES] = '{
        4608000, 2720261, 1437311, 729602, 366217, 183287, 91666, 45836,
        22918, 11459, 5730, 2865, 1432, 716, 358, 179,
        90, 45, 22, 11, 6, 3, 1, 1
    };

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          start = 1'b0;
    logic          busy;
    t_sample       i_field_x = '0;
    t_sample       i_field_y = '0;
    logic          i_cfg_valid = 1'b0;
    logic          o_cfg_ready;
    logic [2:0]    i_cfg_index = '0;
    logic [15:0]   i_cfg_data = '0;
    logic          o_heading_valid;
    t_heading      o_heading;

    // Calibration as the block should hold it.
    longint        cal_iron_x = 0;
    longint        cal_iron_y = 0;
    longint        cal_gain_x = 16384;
    longint        cal_gain_y = 16384;
    longint        cal_declination = 0;

    t_sample_pair  pending_pairs [$];
    t_due_heading  heading_due_q [$];
    int            sender_idle_pct = 0;
    int            error_count = 0;

    compass_heading u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_field_x       (i_field_x),
        .i_field_y       (i_field_y),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_heading_valid (o_heading_valid),
        .o_heading       (o_heading)
    );

    // 100 MHz clock.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Corrects the sample pair and runs the vectoring CORDIC on (yc, xc).
    function automatic t_heading predict_heading(input t_sample fx, input t_sample fy);
        longint xc;
        longint yc;
        longint cx;
        longint sy;
        longint acc;
        longint swap;
        longint dx;
        longint dy;
        xc = (longint'(fx) - cal_iron_x) * cal_gain_x;
        yc = (longint'(fy) - cal_iron_y) * cal_gain_y;
        if (xc == 0 || yc == 0) begin
            return '0;
        end
        cx  = yc;
        sy  = xc;
        acc = 0;
        // Left half plane: turn by a quarter turn into the CORDIC range.
        if (cx < 0) begin
            swap = cx;
            if (sy >= 0) begin
                cx  = sy;
                sy  = -swap;
                acc = QUARTER_TURN;
            end else begin
                cx  = -sy;
                sy  = swap;
                acc = -QUARTER_TURN;
            end
        end
        for (int i = 0; i < CORDIC_STAGES; i++) begin
            dx = sy >>> i;
            dy = cx >>> i;
            if (sy >= 0) begin
                cx  = cx + dx;
                sy  = sy - dy;
                acc = acc + ARCTAN_STEP[i];
            end else begin
                cx  = cx - dx;
                sy  = sy + dy;
                acc = acc - ARCTAN_STEP[i];
            end
        end
        return t_heading'(((acc + 512) >>> 10) + cal_declination);
    endfunction

    // Driver: presents queued sample pairs and records the heading each transaction owes.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                heading_due_q.push_back({i_field_x, i_field_y,
                                         predict_heading(i_field_x, i_field_y)});
            end
            if (start && busy) begin
                // The pair is still waiting to be taken; keep it on the ports.
            end else if (pending_pairs.size() != 0 &&
                         $urandom_range(0, 99) >= sender_idle_pct) begin
                start     <= 1'b1;
                i_field_x <= pending_pairs[0].fx;
                i_field_y <= pending_pairs[0].fy;
                void'(pending_pairs.pop_front());
            end else begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: every strobed heading must match the oldest outstanding one.
    always @(posedge i_clk) begin
        t_due_heading due;
        if (i_rst_n && o_heading_valid === 1'b1) begin
            if (heading_due_q.size() == 0) begin
                $display("%0t: heading %0d strobed with no transaction outstanding",
                         $time, $signed(o_heading));
                error_count++;
            end else begin
                due = heading_due_q.pop_front();
                if (o_heading !== due.heading) begin
                    $display("%0t: x=%0d y=%0d expected heading %0d, got %0d",
                             $time, $signed(due.fx), $signed(due.fy),
                             $signed(due.heading), $signed(o_heading));
                    error_count++;
                end
            end
        end
    end

    // Run limit, well beyond the slowest correct run.
    initial begin
        #2_000_000;
        $display("tb_compass_heading: errors");
        $finish;
    end

    task automatic queue_pair(input t_sample fx, input t_sample fy);
        pending_pairs.push_back({fx, fy});
    endtask

    // Waits until every sample is taken and every heading has come back.
    task automatic drain_pipeline();
        while (pending_pairs.size() != 0 || start || heading_due_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    // One register write transaction; the calibration copy follows on the handshake.
    task automatic set_register(input logic [2:0] index, input logic [15:0] value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        do begin
            @(posedge i_clk);
        end while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (index)
            REG_HARD_IRON_X: cal_iron_x = longint'($signed(value));
            REG_HARD_IRON_Y: cal_iron_y = longint'($signed(value));
            REG_GAIN_X:      cal_gain_x = longint'(value);
            REG_GAIN_Y:      cal_gain_y = longint'(value);
            REG_DECLINATION: cal_declination = longint'($signed(value));
            default: ;
        endcase
    endtask

    function automatic logic [15:0] pick_offset();
        case ($urandom_range(0, 5))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            default: return 16'($urandom());
        endcase
    endfunction

    function automatic logic [15:0] pick_gain();
        case ($urandom_range(0, 5))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'd16384;
            default: return 16'($urandom());
        endcase
    endfunction

    // Stimulus: directed corners first, then randomized calibration phases.
    initial begin
        t_sample     fx;
        t_sample     fy;
        logic [15:0] decl_word;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset calibration: axes, zero axis, full-scale corners, left half plane.
        sender_idle_pct = 0;
        queue_pair(16'sd0, 16'sd0);
        queue_pair(16'sd0, 16'sd1000);
        queue_pair(16'sd1000, 16'sd0);
        queue_pair(16'sd32767, 16'sd32767);
        queue_pair(-16'sd32768, -16'sd32768);
        queue_pair(16'sd32767, -16'sd32768);
        queue_pair(-16'sd32768, 16'sd32767);
        queue_pair(16'sd1, -16'sd1);
        queue_pair(-16'sd1, -16'sd1);
        queue_pair(16'sd12345, -16'sd3);
        queue_pair(-16'sd12345, -16'sd3);
        queue_pair(-16'sd3, 16'sd32767);
        drain_pipeline();

        // Largest corrected magnitudes and a declination beyond its usual range.
        set_register(REG_HARD_IRON_X, 16'h8000);
        set_register(REG_HARD_IRON_Y, 16'h7FFF);
        set_register(REG_GAIN_X, 16'hFFFF);
        set_register(REG_GAIN_Y, 16'hFFFF);
        set_register(REG_DECLINATION, 16'h7FFF);
        queue_pair(16'sd32767, -16'sd32768);
        queue_pair(16'sd32767, 16'sd32767);
        queue_pair(-16'sd32768, 16'sd0);
        queue_pair(16'sd0, -16'sd32768);
        drain_pipeline();
        set_register(REG_DECLINATION, 16'h8000);
        set_register(REG_GAIN_X, 16'h0000);
        queue_pair(16'sd32767, -16'sd32768);
        queue_pair(16'sd100, 16'sd200);
        drain_pipeline();

        // Writes to unused indexes must leave the calibration untouched.
        set_register(REG_GAIN_X, 16'd16384);
        for (int k = REG_DECLINATION + 1; k < 8; k++) begin
            set_register(3'(k), 16'($urandom()));
        end
        queue_pair(16'sd500, -16'sd700);
        queue_pair(-16'sd500, 16'sd700);
        queue_pair(-16'sd32768, -16'sd32768);
        drain_pipeline();

        // Random phases, each with fresh calibration and a sender idle rate of 0, 79 or 32 percent.
        for (int phase = 0; phase < 6; phase++) begin
            case (phase % 3)
                0:       sender_idle_pct = 0;
                1:       sender_idle_pct = 79;
                default: sender_idle_pct = 32;
            endcase
            case ($urandom_range(0, 5))
                0:       decl_word = 16'($urandom());
                1:       decl_word = 16'(-18000);
                2:       decl_word = 16'd18000;
                default: decl_word = 16'($urandom_range(0, 36000) - 18000);
            endcase
            set_register(REG_HARD_IRON_X, pick_offset());
            set_register(REG_HARD_IRON_Y, pick_offset());
            set_register(REG_GAIN_X, pick_gain());
            set_register(REG_GAIN_Y, pick_gain());
            set_register(REG_DECLINATION, decl_word);
            set_register(3'($urandom_range(REG_DECLINATION + 1, 7)), 16'($urandom()));
            for (int n = 0; n < 150; n++) begin
                fx = t_sample'($urandom());
                fy = t_sample'($urandom());
                case ($urandom_range(0, 9))
                    0: fx = t_sample'(cal_iron_x);
                    1: fy = t_sample'(cal_iron_y);
                    2: begin
                        fx = t_sample'(cal_iron_x + $urandom_range(0, 6) - 3);
                        fy = t_sample'(cal_iron_y + $urandom_range(0, 6) - 3);
                    end
                    default: ;
                endcase
                queue_pair(fx, fy);
            end
            drain_pipeline();
        end

        if (error_count == 0) begin
            $display("tb_compass_heading: clean");
        end else begin
            $display("tb_compass_heading: errors");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/chd_pkg.sv
rtl/chd_correct.sv
rtl/chd_cordic.sv
rtl/chd_finish.sv
rtl/compass_heading.sv
test/tb_compass_heading.sv
